// ===== hw/rtl/hac_pkg.sv =====
package hac_pkg;

    // radicand and root widths of the square root units
    localparam int SQ_W   = 70;
    localparam int RT_W   = 35;
    // divider: divisor width, quotient bits, numerator width
    localparam int DN_W   = 35;
    localparam int DQ_W   = 48;
    localparam int DNUM_W = DN_W + DQ_W;
    // force magnitude and component numerator widths
    localparam int FM_W   = 66;
    localparam int NUM_W  = 100;
    localparam int OUT_W  = 48;

    localparam logic [31:0]      PI_Q30   = 32'd3373259426;
    localparam logic [31:0]      YOUNG_RST = 32'd65536;
    localparam logic [OUT_W-1:0] SAT_POS  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG  = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_CONTACT    = 2'd0,
        ST_NO_OVERLAP = 2'd1,
        ST_COINCIDENT = 2'd2,
        ST_SATURATED  = 2'd3
    } t_status;

    typedef enum logic {
        REG_YOUNG    = 1'b0,
        REG_ADHESION = 1'b1
    } t_reg_idx;

    // per-item context carried alongside the arithmetic
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][32:0]  mag;
        logic [32:0]       sum_d;
        logic [63:0]       prod;
        logic [RT_W-1:0]   sep;
        logic [35:0]       delta;
        logic [31:0]       reff;
        logic [63:0]       gr;
        logic              fneg;
        logic [2:0]        big;
    } t_ctx;

endpackage

// ===== hw/rtl/hac_front.sv =====
module hac_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic signed [31:0]        i_first_x,
    input  logic signed [31:0]        i_first_y,
    input  logic signed [31:0]        i_first_z,
    input  logic [31:0]               i_first_diameter,
    input  logic signed [31:0]        i_second_x,
    input  logic signed [31:0]        i_second_y,
    input  logic signed [31:0]        i_second_z,
    input  logic [31:0]               i_second_diameter,
    output logic                      o_valid,
    output logic [hac_pkg::SQ_W-1:0]  o_rad,
    output hac_pkg::t_ctx             o_ctx
);
    import hac_pkg::*;

    logic              r1_valid, r2_valid, r3_valid;
    logic [2:0]        r1_neg, r2_neg, r3_neg;
    logic [2:0][32:0]  r1_mag, r2_mag, r3_mag;
    logic [31:0]       r1_d1, r1_d2;
    logic [2:0][65:0]  r2_sq;
    logic [63:0]       r2_prod, r3_prod;
    logic [32:0]       r2_sum, r3_sum;
    logic [SQ_W-1:0]   r3_rad;

    logic [2:0][32:0]  n_dc;
    logic [2:0]        n_neg;
    logic [2:0][32:0]  n_mag;
    logic [67:0]       n_sqsum;

    always_comb begin
        n_dc[0] = {i_first_x[31], i_first_x} - {i_second_x[31], i_second_x};
        n_dc[1] = {i_first_y[31], i_first_y} - {i_second_y[31], i_second_y};
        n_dc[2] = {i_first_z[31], i_first_z} - {i_second_z[31], i_second_z};
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = n_dc[k][32];
            n_mag[k] = n_dc[k][32] ? (33'd0 - n_dc[k]) : n_dc[k];
        end
        n_sqsum = 68'(r2_sq[0]) + 68'(r2_sq[1]) + 68'(r2_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_neg  <= n_neg;
            r1_mag  <= n_mag;
            r1_d1   <= i_first_diameter;
            r1_d2   <= i_second_diameter;
            for (int k = 0; k < 3; k++) begin
                r2_sq[k] <= r1_mag[k] * r1_mag[k];
            end
            r2_prod <= r1_d1 * r1_d2;
            r2_sum  <= 33'(r1_d1) + 33'(r1_d2);
            r2_neg  <= r1_neg;
            r2_mag  <= r1_mag;
            r3_rad  <= {n_sqsum, 2'b00};
            r3_prod <= r2_prod;
            r3_sum  <= r2_sum;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;
        end
    end

    always_comb begin
        o_ctx       = '0;
        o_ctx.neg   = r3_neg;
        o_ctx.mag   = r3_mag;
        o_ctx.sum_d = r3_sum;
        o_ctx.prod  = r3_prod;
    end

    assign o_valid = r3_valid;
    assign o_rad   = r3_rad;

endmodule

// ===== hw/rtl/hac_sqrt.sv =====
module hac_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [hac_pkg::SQ_W-1:0]  i_rad,
    input  hac_pkg::t_ctx             i_ctx,
    output logic                      o_valid,
    output logic [hac_pkg::RT_W-1:0]  o_root,
    output hac_pkg::t_ctx             o_ctx
);
    import hac_pkg::*;

    // one root bit per stage, restoring digit recurrence
    logic              r_vld  [RT_W];
    logic [RT_W+1:0]   r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [SQ_W-1:0]   r_x    [RT_W];
    t_ctx              r_ctx  [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_step
        logic            p_vld;
        logic [RT_W+1:0] p_rem;
        logic [RT_W-1:0] p_root;
        logic [SQ_W-1:0] p_x;
        t_ctx            p_ctx;
        logic [RT_W+3:0] w_cur, w_trial;
        logic [RT_W+1:0] n_rem;
        logic [RT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_rad;
            assign p_ctx  = i_ctx;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
            assign p_ctx  = r_ctx[k-1];
        end

        always_comb begin
            w_cur   = {p_rem, p_x[SQ_W-1 -: 2]};
            w_trial = {2'b00, p_root, 2'b01};
            if (w_cur >= w_trial) begin
                n_rem  = (RT_W+2)'(w_cur - w_trial);
                n_root = {p_root[RT_W-2:0], 1'b1};
            end else begin
                n_rem  = (RT_W+2)'(w_cur);
                n_root = {p_root[RT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_x[k]    <= {p_x[SQ_W-3:0], 2'b00};
                r_ctx[k]  <= p_ctx;
            end
        end
    end

    assign o_valid = r_vld[RT_W-1];
    assign o_root  = r_root[RT_W-1];
    assign o_ctx   = r_ctx[RT_W-1];

endmodule

// ===== hw/rtl/hac_div.sv =====
module hac_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [hac_pkg::DNUM_W-1:0]  i_num,
    input  logic [hac_pkg::DN_W-1:0]    i_den,
    input  hac_pkg::t_ctx               i_ctx,
    output logic                        o_valid,
    output logic [hac_pkg::DQ_W-1:0]    o_quo,
    output hac_pkg::t_ctx               o_ctx
);
    import hac_pkg::*;

    // top part of the numerator must already lie below the divisor
    logic             r_vld [DQ_W];
    logic [DN_W-1:0]  r_rem [DQ_W];
    logic [DQ_W-1:0]  r_x   [DQ_W];
    logic [DQ_W-1:0]  r_quo [DQ_W];
    logic [DN_W-1:0]  r_den [DQ_W];
    t_ctx             r_ctx [DQ_W];

    for (genvar k = 0; k < DQ_W; k++) begin : g_step
        logic            p_vld;
        logic [DN_W-1:0] p_rem;
        logic [DQ_W-1:0] p_x;
        logic [DQ_W-1:0] p_quo;
        logic [DN_W-1:0] p_den;
        t_ctx            p_ctx;
        logic [DN_W:0]   w_t;
        logic [DN_W-1:0] n_rem;
        logic            n_bit;

        if (k == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_rem = i_num[DNUM_W-1 -: DN_W];
            assign p_x   = i_num[DQ_W-1:0];
            assign p_quo = '0;
            assign p_den = i_den;
            assign p_ctx = i_ctx;
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_rem = r_rem[k-1];
            assign p_x   = r_x[k-1];
            assign p_quo = r_quo[k-1];
            assign p_den = r_den[k-1];
            assign p_ctx = r_ctx[k-1];
        end

        always_comb begin
            w_t = {p_rem, p_x[DQ_W-1]};
            if (w_t >= {1'b0, p_den}) begin
                n_rem = DN_W'(w_t - {1'b0, p_den});
                n_bit = 1'b1;
            end else begin
                n_rem = DN_W'(w_t);
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_x[k]   <= {p_x[DQ_W-2:0], 1'b0};
                r_quo[k] <= {p_quo[DQ_W-2:0], n_bit};
                r_den[k] <= p_den;
                r_ctx[k] <= p_ctx;
            end
        end
    end

    assign o_valid = r_vld[DQ_W-1];
    assign o_quo   = r_quo[DQ_W-1];
    assign o_ctx   = r_ctx[DQ_W-1];

endmodule

// ===== hw/rtl/hac_mid.sv =====
module hac_mid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [hac_pkg::RT_W-1:0]            i_root,
    input  hac_pkg::t_ctx                       i_ctx,
    input  logic [31:0]                         i_young,
    output logic                                o_valid,
    output logic [2:0][hac_pkg::DNUM_W-1:0]     o_num,
    output hac_pkg::t_ctx                       o_ctx
);
    import hac_pkg::*;

    localparam int NCH   = 9;          // 8-bit chunks of the divide by three
    localparam int D3_W  = NCH * 8;
    localparam int S_D3  = 3;          // first chunk stage
    localparam int S_CMP = S_D3 + NCH;
    localparam int S_MUL = S_CMP + 1;
    localparam int S_SUM = S_MUL + 1;
    localparam int S_BIG = S_SUM + 1;
    localparam int NST   = S_BIG + 1;

    logic        r_vld [NST];
    t_ctx        r_ctx [NST];
    t_ctx        w_ctx [NST];
    logic        w_vld [NST];

    // repulsive chain
    logic [65:0]          r_h;
    logic [63:0]          r_adl, r_adh;
    logic [64:0]          r_pl, r_ph;
    // adhesive term is not formed before the second stage
    logic [48:0]          r_adm [1:S_CMP-1];
    logic [65:0]          r_rr;
    logic [D3_W-1:0]      r_dx [NCH];
    logic [D3_W-1:0]      r_dq [NCH];
    logic [1:0]           r_dr [NCH];
    logic [FM_W-1:0]      r_fmag;
    logic [2:0][66:0]     r_lo, r_hi;
    logic [2:0][NUM_W-1:0] r_num;
    logic [2:0][DNUM_W-1:0] r_onum;

    logic [33:0]          w_dpos;
    logic [95:0]          w_adsum;
    logic [97:0]          w_rep;
    logic [FM_W-1:0]      w_repq;
    logic                 w_fneg;
    logic [FM_W-1:0]      w_fmag;
    logic [2:0]           w_big;
    logic [2:0][DNUM_W-1:0] w_onum;

    assign w_dpos  = i_ctx.delta[35] ? 34'd0 : i_ctx.delta[33:0];
    assign w_adsum = {r_adh, 32'd0} + 96'(r_adl);
    assign w_rep   = 98'(r_pl) + {r_ph, 33'd0};
    assign w_repq  = r_dq[NCH-1][FM_W-1:0];

    always_comb begin
        if (w_repq < FM_W'(r_adm[S_CMP-1])) begin
            w_fneg = 1'b1;
            w_fmag = FM_W'(r_adm[S_CMP-1]) - w_repq;
        end else begin
            w_fneg = 1'b0;
            w_fmag = w_repq - FM_W'(r_adm[S_CMP-1]);
        end
        for (int k = 0; k < 3; k++) begin
            // a quotient of 2^48 or more saturates whatever its sign
            w_big[k]  = r_num[k][NUM_W-1:DQ_W] >= (NUM_W-DQ_W)'(r_ctx[S_SUM].sep);
            w_onum[k] = w_big[k] ? '0 : r_num[k][DNUM_W-1:0];
        end
    end

    always_comb begin
        for (int i = 0; i < NST; i++) begin
            if (i == 0) begin
                w_vld[i] = i_valid;
                w_ctx[i] = i_ctx;
            end else begin
                w_vld[i] = r_vld[i-1];
                w_ctx[i] = r_ctx[i-1];
            end
        end
        w_ctx[S_CMP].fneg = w_fneg;
        w_ctx[S_BIG].big  = w_big;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_en) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= w_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NST; i++) begin
                r_ctx[i] <= w_ctx[i];
            end
            r_h   <= 66'(i_root * w_dpos);
            r_adl <= i_ctx.gr[31:0] * PI_Q30;
            r_adh <= i_ctx.gr[63:32] * PI_Q30;
            r_pl  <= r_h[32:0] * i_young;
            r_ph  <= r_h[65:33] * i_young;
            r_adm[1] <= w_adsum[95:47];
            for (int i = 2; i < S_CMP; i++) begin
                r_adm[i] <= r_adm[i-1];
            end
            r_rr   <= w_rep[97:32];
            r_fmag <= w_fmag;
            for (int k = 0; k < 3; k++) begin
                r_lo[k]  <= r_fmag[32:0] * {r_ctx[S_CMP].mag[k], 1'b0};
                r_hi[k]  <= r_fmag[65:33] * {r_ctx[S_CMP].mag[k], 1'b0};
                r_num[k] <= NUM_W'(r_lo[k]) + {r_hi[k], 33'd0};
            end
            r_onum <= w_onum;
        end
    end

    // long division by three, eight quotient bits per stage
    for (genvar j = 0; j < NCH; j++) begin : g_d3
        logic [D3_W-1:0] p_x, p_q;
        logic [1:0]      p_r;
        logic [9:0]      w_v;
        logic [19:0]     w_p;
        logic [7:0]      n_q;
        logic [9:0]      w_r;

        if (j == 0) begin : g_first
            assign p_x = D3_W'(r_rr);
            assign p_q = '0;
            assign p_r = '0;
        end else begin : g_next
            assign p_x = r_dx[j-1];
            assign p_q = r_dq[j-1];
            assign p_r = r_dr[j-1];
        end

        always_comb begin
            w_v = {p_r, p_x[D3_W-1 -: 8]};
            w_p = w_v * 10'd683;
            n_q = w_p[18:11];
            w_r = w_v - {1'b0, n_q, 1'b0} - {2'b00, n_q};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dx[j] <= {p_x[D3_W-9:0], 8'd0};
                r_dq[j] <= {p_q[D3_W-9:0], n_q};
                r_dr[j] <= w_r[1:0];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_ctx   = r_ctx[NST-1];
    assign o_num   = r_onum;

endmodule

// ===== hw/rtl/hertz_adhesive_contact_force.sv =====
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// the path runs through two 35-stage square roots and two levels of 48-stage dividers
// reset (synchronous, active low) empties the pipeline and sets the modulus
// to 1.0 and the adhesion energy to 0
module hertz_adhesive_contact_force (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_first_z,
    input  logic [31:0]        i_first_diameter,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic signed [31:0] i_second_z,
    input  logic [31:0]        i_second_diameter,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic [1:0]         o_contact_status
);
    import hac_pkg::*;

    logic [31:0] r_young_mod, r_adhesion;
    logic        w_en;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_young_mod <= YOUNG_RST;
            r_adhesion  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_YOUNG:    r_young_mod <= pwdata;
                REG_ADHESION: r_adhesion  <= pwdata;
                default:      r_young_mod <= r_young_mod;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_YOUNG:    prdata = r_young_mod;
            REG_ADHESION: prdata = r_adhesion;
            default:      prdata = '0;
        endcase
    end

    // whole pipeline advances unless a finished item is held at the output
    assign w_en    = !o_valid || !i_stall;
    assign o_stall = o_valid && i_stall;

    logic              f_valid;
    logic [SQ_W-1:0]   f_rad;
    t_ctx              f_ctx;

    hac_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_first_x, .i_first_y, .i_first_z, .i_first_diameter,
        .i_second_x, .i_second_y, .i_second_z, .i_second_diameter,
        .o_valid(f_valid), .o_rad(f_rad), .o_ctx(f_ctx)
    );

    logic              q1_valid;
    logic [RT_W-1:0]   q1_root;
    t_ctx              q1_ctx;

    hac_sqrt u_sqrt_dist (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(f_valid), .i_rad(f_rad), .i_ctx(f_ctx),
        .o_valid(q1_valid), .o_root(q1_root), .o_ctx(q1_ctx)
    );

    // overlap and effective radius division
    logic              r_t1_valid;
    logic [DNUM_W-1:0] r_t1_num;
    logic [DN_W-1:0]   r_t1_den;
    t_ctx              r_t1_ctx;
    t_ctx              n_t1_ctx;

    always_comb begin
        n_t1_ctx       = q1_ctx;
        n_t1_ctx.sep   = q1_root;
        n_t1_ctx.delta = 36'(q1_ctx.sum_d) - 36'(q1_root);
    end

    logic              d1_valid;
    logic [DQ_W-1:0]   d1_quo;
    t_ctx              d1_ctx;

    hac_div u_div_reff (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_t1_valid),
        .i_num(r_t1_num), .i_den(r_t1_den), .i_ctx(r_t1_ctx),
        .o_valid(d1_valid), .o_quo(d1_quo), .o_ctx(d1_ctx)
    );

    logic              r_t2_valid;
    logic [SQ_W-1:0]   r_t2_rad;
    t_ctx              r_t2_ctx;
    t_ctx              n_t2_ctx;
    logic [31:0]       w_reff;
    logic [33:0]       w_dpos;

    always_comb begin
        w_reff        = (d1_ctx.sum_d == '0) ? 32'd0 : d1_quo[31:0];
        w_dpos        = d1_ctx.delta[35] ? 34'd0 : d1_ctx.delta[33:0];
        n_t2_ctx      = d1_ctx;
        n_t2_ctx.reff = w_reff;
        n_t2_ctx.gr   = w_reff * r_adhesion;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
            r_t2_valid <= 1'b0;
        end else if (w_en) begin
            r_t1_valid <= q1_valid;
            r_t2_valid <= d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_num <= DNUM_W'(q1_ctx.prod);
            r_t1_den <= DN_W'(q1_ctx.sum_d);
            r_t1_ctx <= n_t1_ctx;
            r_t2_rad <= SQ_W'(w_reff * w_dpos);
            r_t2_ctx <= n_t2_ctx;
        end
    end

    logic              q2_valid;
    logic [RT_W-1:0]   q2_root;
    t_ctx              q2_ctx;

    hac_sqrt u_sqrt_s (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(r_t2_valid), .i_rad(r_t2_rad),
        .i_ctx(r_t2_ctx), .o_valid(q2_valid), .o_root(q2_root), .o_ctx(q2_ctx)
    );

    logic                   m_valid;
    logic [2:0][DNUM_W-1:0] m_num;
    t_ctx                   m_ctx;

    hac_mid u_mid (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(q2_valid), .i_root(q2_root),
        .i_ctx(q2_ctx), .i_young(r_young_mod),
        .o_valid(m_valid), .o_num(m_num), .o_ctx(m_ctx)
    );

    // component division by the distance
    logic [2:0]            c_valid;
    logic [2:0][DQ_W-1:0]  c_quo;
    t_ctx                  c_ctx [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        hac_div u_div_comp (
            .i_clk, .i_rst_n, .i_en(w_en), .i_valid(m_valid),
            .i_num(m_num[k]), .i_den(m_ctx.sep), .i_ctx(m_ctx),
            .o_valid(c_valid[k]), .o_quo(c_quo[k]), .o_ctx(c_ctx[k])
        );
    end

    logic [2:0][OUT_W-1:0] n_force;
    logic [2:0]            n_sat;
    logic [1:0]            n_status;
    logic                  w_neg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_neg = c_ctx[0].fneg ^ c_ctx[0].neg[k];
            if (w_neg) begin
                n_sat[k]   = c_ctx[0].big[k] || (c_quo[k] > SAT_NEG);
                n_force[k] = OUT_W'(0) - (n_sat[k] ? SAT_NEG : c_quo[k]);
            end else begin
                n_sat[k]   = c_ctx[0].big[k] || c_quo[k][DQ_W-1];
                n_force[k] = n_sat[k] ? SAT_POS : c_quo[k];
            end
        end
        priority if (c_ctx[0].delta[35]) begin
            n_status = ST_NO_OVERLAP;
            n_force  = '0;
        end else if (c_ctx[0].sep == '0) begin
            n_status = ST_COINCIDENT;
            n_force  = '0;
        end else if (n_sat != 3'b000) begin
            n_status = ST_SATURATED;
        end else begin
            n_status = ST_CONTACT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= c_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_force_x        <= n_force[0];
            o_force_y        <= n_force[1];
            o_force_z        <= n_force[2];
            o_contact_status <= n_status;
        end
    end

endmodule

// ===== hw/rtl/hac_checker.sv =====
module hac_assertions (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [47:0] o_force_x,
    input logic signed [47:0] o_force_y,
    input logic signed [47:0] o_force_z,
    input logic [1:0]         o_contact_status
);
    import hac_pkg::*;

    // a result held at the output keeps its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_force_x) && $stable(o_force_y)
            && $stable(o_force_z) && $stable(o_contact_status))
        else $error("held result changed");

    // no contact means no force
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_contact_status == ST_NO_OVERLAP || o_contact_status == ST_COINCIDENT)
            |-> o_force_x == '0 && o_force_y == '0 && o_force_z == '0)
        else $error("force on a non-contact item");

    // input is held off only by a stalled result
    a_stall: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind hertz_adhesive_contact_force hac_assertions u_hac_assertions (.*);
